>>> hw/rtl/tdbc_pkg.sv
package tdbc_pkg;

    typedef enum logic [1:0] {
        REQ_CLICK      = 2'd0,
        REQ_HOLD_START = 2'd1,
        REQ_HOLD_TICK  = 2'd2,
        REQ_UNUSED     = 2'd3
    } req_type_t;

    localparam logic [7:0] CFG_HOLD_INTERVAL   = 8'd0;
    localparam logic [7:0] CFG_RESET_THRESHOLD = 8'd1;

    localparam logic [7:0] HOLD_INTERVAL_RESET   = 8'd15;
    localparam logic [7:0] RESET_THRESHOLD_RESET = 8'd20;

    // Brightness bands that set the ramp step size.
    localparam logic [7:0] LEVEL_SLOW_END = 8'd30;
    localparam logic [7:0] LEVEL_MID_END  = 8'd140;
    localparam logic [7:0] LEVEL_FAST     = 8'd190;

    localparam logic [2:0] STEP_SLOW    = 3'd1;
    localparam logic [2:0] STEP_MID     = 3'd2;
    localparam logic [2:0] STEP_UPPER   = 3'd3;
    localparam logic [2:0] STEP_FASTEST = 3'd4;

    localparam logic [7:0] CLICK_SINGLE = 8'd1;
    localparam logic [7:0] CLICK_DOUBLE = 8'd2;

    typedef struct packed {
        logic       on_flag;
        logic [7:0] level;
        logic       ramp_up;
        logic [7:0] last_step_time;
    } tdbc_state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] click_count;
        logic [7:0] now_ms;
    } tdbc_item_t;

    typedef struct packed {
        logic       light_on;
        logic [7:0] brightness;
        logic       advance_animation;
        logic       factory_reset;
    } tdbc_result_t;

endpackage

>>> hw/rtl/tdbc_core.sv
module tdbc_core import tdbc_pkg::*; (
    input  tdbc_state_t  cur_state,
    input  tdbc_item_t   item,
    input  logic [7:0]   hold_interval_ms,
    input  logic [7:0]   reset_click_threshold,
    output tdbc_state_t  next_state,
    output tdbc_result_t result
);

    logic [7:0] base_level;
    logic       base_ramp;
    logic       do_step;
    logic [7:0] elapsed;
    logic [2:0] step_size;
    logic [8:0] step_sum;
    logic       ramp_dir;
    logic       advance;
    logic       freset;

    assign elapsed = item.now_ms - cur_state.last_step_time;

    always_comb begin
        next_state = cur_state;
        base_level = cur_state.level;
        base_ramp  = cur_state.ramp_up;
        do_step    = 1'b0;
        advance    = 1'b0;
        freset     = 1'b0;
        case (req_type_t'(item.req_type))
            REQ_CLICK: begin
                if (item.click_count == CLICK_SINGLE) begin
                    next_state.on_flag = ~cur_state.on_flag;
                end else if (item.click_count == CLICK_DOUBLE) begin
                    next_state.on_flag = 1'b1;
                    advance            = 1'b1;
                end else if (item.click_count >= reset_click_threshold) begin
                    freset = 1'b1;
                end
            end
            REQ_HOLD_START: begin
                // An off light starts dark and ramps up; an on light reverses.
                if (!cur_state.on_flag) begin
                    base_level = 8'd0;
                    base_ramp  = 1'b1;
                end else begin
                    base_ramp = ~cur_state.ramp_up;
                end
                next_state.on_flag = 1'b1;
                do_step            = 1'b1;
            end
            REQ_HOLD_TICK: begin
                do_step = (elapsed >= hold_interval_ms);
            end
            default: begin
            end
        endcase

        if (base_level < LEVEL_SLOW_END) begin
            step_size = STEP_SLOW;
        end else if (base_level > LEVEL_MID_END && base_level < LEVEL_FAST) begin
            step_size = STEP_UPPER;
        end else if (base_level >= LEVEL_FAST) begin
            step_size = STEP_FASTEST;
        end else begin
            step_size = STEP_MID;
        end

        // The ramp turns round at either end so the level never wraps.
        step_sum = {1'b0, base_level} + {6'd0, step_size};
        if (step_sum[8]) begin
            ramp_dir = 1'b0;
        end else if (base_level < {5'd0, step_size}) begin
            ramp_dir = 1'b1;
        end else begin
            ramp_dir = base_ramp;
        end

        if (do_step) begin
            next_state.ramp_up        = ramp_dir;
            next_state.last_step_time = item.now_ms;
            next_state.level          = ramp_dir ? step_sum[7:0]
                                                 : base_level - {5'd0, step_size};
        end

        result.light_on          = next_state.on_flag;
        result.brightness        = next_state.level;
        result.advance_animation = advance;
        result.factory_reset     = freset;
    end

endmodule

>>> hw/rtl/touch_dimmer_button_control.sv
// Touch dimmer button control.
// Input items arrive on the s_ stream: s_tuser carries the event kind (click,
// hold start, holding tick), s_tdata the click count and the low byte of the
// millisecond time. Every input item yields exactly one result item on the m_
// stream with the light on flag, the brightness and the two one-item pulses
// advance_animation and factory_reset. Light state lives inside the block.
// The cfg channel writes the hold interval (index 0) and the factory reset
// click threshold (index 1); it is always ready. The user must use it only
// while idle; the block does not enforce this. An item is registered in the
// input register on acceptance and its result then in the result register,
// which raises m_tvalid. The light state is updated in the same cycle that
// loads the result register, which keeps one item per cycle sustained while
// m_tready is high. When the receiver stalls, the result register holds and
// one more item waits in the input register before s_tready drops. Reset
// (aresetn low, synchronous) turns the light off at brightness 0, ramp down,
// last step time 0, and restores register defaults.
module touch_dimmer_button_control import tdbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] click_count, [15:8] now_ms
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] light_on, [8:1] brightness,
                                   // [9] advance_animation, [10] factory_reset
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic         in_valid_reg;
    tdbc_item_t   in_item_reg;
    logic         out_valid_reg;
    tdbc_result_t out_result_reg;
    tdbc_state_t  state_reg;
    tdbc_state_t  state_next;
    tdbc_result_t result_next;
    logic [7:0]   hold_interval_reg;
    logic [7:0]   reset_threshold_reg;
    logic         load_out;

    assign load_out  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || load_out;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_result_reg.factory_reset,
                        out_result_reg.advance_animation,
                        out_result_reg.brightness, out_result_reg.light_on};

    tdbc_core u_core (
        .cur_state             (state_reg),
        .item                  (in_item_reg),
        .hold_interval_ms      (hold_interval_reg),
        .reset_click_threshold (reset_threshold_reg),
        .next_state            (state_next),
        .result                (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            state_reg           <= '0;
            hold_interval_reg   <= HOLD_INTERVAL_RESET;
            reset_threshold_reg <= RESET_THRESHOLD_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (load_out) begin
                in_valid_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HOLD_INTERVAL) begin
                    hold_interval_reg <= cfg_data;
                end else if (cfg_index == CFG_RESET_THRESHOLD) begin
                    reset_threshold_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= {s_tuser, s_tdata[7:0], s_tdata[15:8]};
        end
        if (load_out) begin
            out_result_reg <= result_next;
        end
    end

`ifndef SYNTH
    // The pending result always mirrors the light state it was computed into.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_result_reg.light_on == state_reg.on_flag
                           && out_result_reg.brightness == state_reg.level))
        else $error("result does not match light state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_result_reg.advance_animation
                            && out_result_reg.factory_reset))
        else $error("both pulses set in one item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !load_out) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("waiting input item lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(state_reg))
        else $error("light state moved during a stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_result_reg.factory_reset && out_valid_reg) |-> out_result_reg.light_on
            == $past(state_reg.on_flag) || !$past(load_out))
        else $error("factory reset changed the light");
`endif

endmodule
